// File: rtl/source_text_tokenizer_defines.svh
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Check in the same cycle: whenever pre holds, post holds too.
`define STT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tokenizer check failed");

// Delayed check: whenever pre holds, post holds at the next edge.
`define STT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tokenizer check failed");

`endif

// File: rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

    localparam int LENGTH_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // widths of the token fields as they leave the block
    localparam int KIND_W    = 3;
    localparam int TOK_LEN_W = 16;
    localparam int TOK_OFF_W = 32;
    localparam int TOK_POS_W = 16;

    localparam logic [7:0] CHR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHR_UPPER_HI = 8'h5A;
    localparam logic [7:0] CHR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHR_LOWER_HI = 8'h7A;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHR_QUOTE   = 8'h22;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENT       = 3'd0,
        KIND_NUMBER      = 3'd1,
        KIND_OPERATOR    = 3'd2,
        KIND_STRING      = 3'd3,
        KIND_UNKNOWN     = 3'd4,
        KIND_OPEN_STRING = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_ERROR  = 3'd4
    } mode_t;

    typedef enum logic {
        BACK_FIRST  = 1'b0,
        BACK_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [TOK_LEN_W-1:0]  length;
        logic [TOK_OFF_W-1:0]  offset;
        logic [TOK_POS_W-1:0]  line;
        logic [TOK_POS_W-1:0]  column;
    } token_t;

    // all tokens caused by one input word
    typedef struct packed {
        token_t first;
        token_t second;
        logic   two;
    } record_t;

endpackage

// File: rtl/stt_front.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_front
    import stt_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    input  logic          accept,
    output logic          push,
    output record_t       push_rec
);

    mode_t                    mode_reg, mode_next;
    logic [LENGTH_BITS-1:0]   plen_reg, plen_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [OFFSET_BITS-1:0]   off_reg, off_next;
    logic [OFFSET_BITS-1:0]   poff_reg, poff_next;
    logic [POSITION_BITS-1:0] pline_reg, pline_next;
    logic [POSITION_BITS-1:0] pcol_reg, pcol_next;

    logic  is_digit, is_alpha, is_ident, is_space, is_eq, is_quote;
    logic  sc_emit, sc_begin;
    kind_t sc_kind;
    mode_t sc_mode;

    assign is_digit = (text_byte >= CHR_DIGIT_LO) && (text_byte <= CHR_DIGIT_HI);
    assign is_alpha = ((text_byte >= CHR_UPPER_LO) && (text_byte <= CHR_UPPER_HI))
                   || ((text_byte >= CHR_LOWER_LO) && (text_byte <= CHR_LOWER_HI))
                   || (text_byte == CHR_UNDERSCORE);
    assign is_ident = is_alpha || is_digit;
    assign is_space = (text_byte == CHR_SPACE) || (text_byte == CHR_NEWLINE);
    assign is_eq    = (text_byte == CHR_EQUALS);
    assign is_quote = (text_byte == CHR_QUOTE);

    // classify the word as the first byte of a new token
    always_comb
    begin
        sc_emit  = 1'b0;
        sc_begin = 1'b0;
        sc_kind  = KIND_OPERATOR;
        sc_mode  = MODE_IDLE;
        if (is_space)
        begin
            sc_mode = MODE_IDLE;
        end
        else if (is_eq)
        begin
            sc_emit = 1'b1;
        end
        else if (is_quote)
        begin
            sc_mode  = MODE_STRING;
            sc_begin = 1'b1;
        end
        else if (is_digit)
        begin
            sc_mode  = MODE_NUMBER;
            sc_begin = 1'b1;
        end
        else if (is_alpha)
        begin
            sc_mode  = MODE_IDENT;
            sc_begin = 1'b1;
        end
        else
        begin
            sc_emit = 1'b1;
            sc_kind = KIND_UNKNOWN;
            sc_mode = MODE_ERROR;
        end
    end

    token_t     pend_tok, cur_tok, eot_tok, t0, t1;
    logic [1:0] cnt;
    logic       plen_sat;

    assign plen_sat = (plen_reg == '1);

    always_comb
    begin
        pend_tok.kind   = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        pend_tok.length = TOK_LEN_W'(plen_reg);
        pend_tok.offset = TOK_OFF_W'(poff_reg);
        pend_tok.line   = TOK_POS_W'(pline_reg);
        pend_tok.column = TOK_POS_W'(pcol_reg);

        cur_tok.kind    = sc_kind;
        cur_tok.length  = TOK_LEN_W'(1);
        cur_tok.offset  = TOK_OFF_W'(off_reg);
        cur_tok.line    = TOK_POS_W'(line_reg);
        cur_tok.column  = TOK_POS_W'(col_reg);
    end

    always_comb
    begin
        mode_next  = mode_reg;
        plen_next  = plen_reg;
        poff_next  = poff_reg;
        pline_next = pline_reg;
        pcol_next  = pcol_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        cnt        = 2'd0;
        t0         = pend_tok;
        t1         = cur_tok;
        eot_tok    = pend_tok;

        unique case (mode_reg)
            MODE_ERROR:
            begin
                mode_next = MODE_ERROR;
            end
            MODE_IDENT, MODE_NUMBER:
            begin
                if ((mode_reg == MODE_IDENT) ? is_ident : is_digit)
                begin
                    plen_next = plen_sat ? plen_reg : plen_reg + 1'b1;
                end
                else
                begin
                    cnt = 2'd1;
                    t0  = pend_tok;
                    if (sc_emit)
                    begin
                        t1  = cur_tok;
                        cnt = 2'd2;
                    end
                    mode_next = sc_mode;
                end
            end
            MODE_STRING:
            begin
                plen_next = plen_sat ? plen_reg : plen_reg + 1'b1;
                if (is_quote)
                begin
                    t0      = pend_tok;
                    t0.kind = KIND_STRING;
                    t0.length = TOK_LEN_W'(plen_next);
                    cnt       = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                if (sc_emit)
                begin
                    t0  = cur_tok;
                    cnt = 2'd1;
                end
                mode_next = sc_mode;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // a token byte seen from idle, or one that ends an identifier or number, opens a new pending token
        if (mode_reg != MODE_ERROR && mode_reg != MODE_STRING && sc_begin
            && !((mode_reg == MODE_IDENT && is_ident)
                 || (mode_reg == MODE_NUMBER && is_digit)))
        begin
            plen_next  = LENGTH_BITS'(1);
            poff_next  = off_reg;
            pline_next = line_reg;
            pcol_next  = col_reg;
        end

        if (mode_reg != MODE_ERROR)
        begin
            off_next = off_reg + 1'b1;
            if (text_byte == CHR_NEWLINE)
            begin
                line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
                col_next  = POSITION_BITS'(1);
            end
            else
            begin
                col_next = (col_reg == '1) ? col_reg : col_reg + 1'b1;
            end
        end

        if (end_of_text)
        begin
            eot_tok.length = TOK_LEN_W'(plen_next);
            eot_tok.offset = TOK_OFF_W'(poff_next);
            eot_tok.line   = TOK_POS_W'(pline_next);
            eot_tok.column = TOK_POS_W'(pcol_next);
            case (mode_next)
                MODE_IDENT:  eot_tok.kind = KIND_IDENT;
                MODE_NUMBER: eot_tok.kind = KIND_NUMBER;
                default:     eot_tok.kind = KIND_OPEN_STRING;
            endcase
            if (mode_next == MODE_IDENT || mode_next == MODE_NUMBER
                || mode_next == MODE_STRING)
            begin
                if (cnt == 2'd0)
                begin
                    t0 = eot_tok;
                end
                else
                begin
                    t1 = eot_tok;
                end
                cnt = cnt + 2'd1;
            end
            mode_next  = MODE_IDLE;
            plen_next  = '0;
            off_next   = '0;
            line_next  = POSITION_BITS'(1);
            col_next   = POSITION_BITS'(1);
            poff_next  = '0;
            pline_next = POSITION_BITS'(1);
            pcol_next  = POSITION_BITS'(1);
        end
    end

    assign push            = accept && (cnt != 2'd0);
    assign push_rec.first  = t0;
    assign push_rec.second = t1;
    assign push_rec.two    = (cnt == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            plen_reg  <= '0;
            col_reg   <= POSITION_BITS'(1);
            line_reg  <= POSITION_BITS'(1);
            off_reg   <= '0;
            poff_reg  <= '0;
            pline_reg <= POSITION_BITS'(1);
            pcol_reg  <= POSITION_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            plen_reg  <= plen_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            off_reg   <= off_next;
            poff_reg  <= poff_next;
            pline_reg <= pline_next;
            pcol_reg  <= pcol_next;
        end
    end

    `STT_ASSERT_NEXT(a_eot_returns_idle, accept && end_of_text, mode_reg == MODE_IDLE && off_reg == '0)

endmodule

// File: rtl/stt_queue.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_queue
    import stt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    input  logic    pop,
    output logic    has_space,
    output logic    has_data,
    output record_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign has_space = (count_reg != CNT_W'(DEPTH));
    assign has_data  = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && has_data;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `STT_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CNT_W'(DEPTH))
    `STT_ASSERT_NOW(a_no_push_when_full, push, has_space)

endmodule

// File: rtl/stt_back.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_back
    import stt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  has_data,
    input  record_t               head,
    output logic                  pop,
    output logic                  token_valid,
    input  logic                  token_ready,
    output logic [KIND_W-1:0]     token_kind,
    output logic [TOK_LEN_W-1:0]  token_length,
    output logic [TOK_OFF_W-1:0]  start_offset,
    output logic [TOK_POS_W-1:0]  start_line,
    output logic [TOK_POS_W-1:0]  start_column,
    output logic                  last_of_run
);

    back_state_t state_reg, state_next;
    token_t      tok;
    logic        last;

    always_comb
    begin
        state_next = state_reg;
        tok        = head.first;
        last       = !head.two;
        unique case (state_reg)
            BACK_FIRST:
            begin
                tok  = head.first;
                last = !head.two;
            end
            BACK_SECOND:
            begin
                tok  = head.second;
                last = 1'b1;
            end
            default:
            begin
                tok  = head.first;
                last = !head.two;
            end
        endcase
        // step to the second token, or release the word once its last token leaves
        if (has_data && token_ready)
        begin
            state_next = last ? BACK_FIRST : BACK_SECOND;
        end
    end

    assign pop          = has_data && token_ready && last;
    assign token_valid  = has_data;
    assign token_kind   = tok.kind;
    assign token_length = tok.length;
    assign start_offset = tok.offset;
    assign start_line   = tok.line;
    assign start_column = tok.column;
    assign last_of_run  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_FIRST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `STT_ASSERT_NOW(a_second_needs_pair, state_reg == BACK_SECOND, has_data && head.two)
    `STT_ASSERT_NEXT(a_first_then_second, token_valid && token_ready && !last_of_run, state_reg == BACK_SECOND)

endmodule

// File: rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Tokens of an accepted word are stored in the queue and offered at the output from its head.
// One text byte per cycle while the queue has space; two tokens from one byte leave in turn.
// A queue of QUEUE_DEPTH words between scanner and output absorbs those two-token bytes.
// Reset (rst_n low, asynchronous) empties the queue and sets line and column to 1,
// offset to 0 and the scanner to idle.

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output logic                  token_valid,
    input  logic                  token_ready,
    output logic [KIND_W-1:0]     token_kind,
    output logic [TOK_LEN_W-1:0]  token_length,
    output logic [TOK_OFF_W-1:0]  start_offset,
    output logic [TOK_POS_W-1:0]  start_line,
    output logic [TOK_POS_W-1:0]  start_column,
    output logic                  last_of_run
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    has_space;
    logic    has_data;
    record_t push_rec;
    record_t head;

    assign text_ready = has_space;
    assign accept     = text_valid && has_space;

    stt_front #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .accept      (accept),
        .push        (push),
        .push_rec    (push_rec)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .has_space (has_space),
        .has_data  (has_data),
        .head      (head)
    );

    stt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .has_data     (has_data),
        .head         (head),
        .pop          (pop),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .token_length (token_length),
        .start_offset (start_offset),
        .start_line   (start_line),
        .start_column (start_column),
        .last_of_run  (last_of_run)
    );

endmodule
